[rtl/wfpd_pkg.sv]
// Shared types, register indexes, codes and helper functions of the wall-following PD drive.
`timescale 1ns / 1ps

package wfpd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_LEFT_WALL_LEVEL  = 3'd0;
  localparam logic [2:0] REG_RIGHT_WALL_LEVEL = 3'd1;
  localparam logic [2:0] REG_FRONT_STOP_LEVEL = 3'd2;
  localparam logic [2:0] REG_BASE_SPEED       = 3'd3;
  localparam logic [2:0] REG_TRAVEL_TARGET    = 3'd4;
  localparam logic [2:0] REG_ENCODER_GAINS    = 3'd5;
  localparam logic [2:0] REG_BOTH_WALL_GAINS  = 3'd6;
  localparam logic [2:0] REG_SIDE_WALL_GAINS  = 3'd7;

  // Register reset values
  localparam logic [11:0] LEFT_WALL_LEVEL_RST  = 12'd1000;
  localparam logic [11:0] RIGHT_WALL_LEVEL_RST = 12'd1000;
  localparam logic [11:0] FRONT_STOP_LEVEL_RST = 12'd2000;
  localparam logic [7:0]  BASE_SPEED_RST       = 8'd100;
  localparam logic [15:0] TRAVEL_TARGET_RST    = 16'd1000;
  localparam logic [31:0] ENCODER_GAINS_RST    = 32'h0033_0200;
  localparam logic [31:0] BOTH_WALL_GAINS_RST  = 32'h0003_001A;
  localparam logic [31:0] SIDE_WALL_GAINS_RST  = 32'h0500_0080;

  // Move status codes
  localparam logic [1:0] STATUS_DRIVING = 2'd0;
  localparam logic [1:0] STATUS_TARGET  = 2'd1;
  localparam logic [1:0] STATUS_FRONT   = 2'd2;

  // Wall mode codes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_BOTH  = 2'd1;
  localparam logic [1:0] MODE_LEFT  = 2'd2;
  localparam logic [1:0] MODE_RIGHT = 2'd3;

  // Item codes
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Datapath widths
  localparam int OPND_W = 27;  // multiplier data operand, signed
  localparam int ACC_W  = 44;  // product and accumulator, signed
  localparam int CORR_W = 36;  // accumulator after the Q8.8 scale-down

  typedef struct packed {
    logic               func;
    logic signed [15:0] wheel1_edges;
    logic signed [15:0] wheel2_edges;
    logic        [11:0] ir_front_a;
    logic        [11:0] ir_side_left;
    logic        [11:0] ir_side_right;
    logic        [11:0] ir_front_b;
  } in_t;

  typedef struct packed {
    logic [7:0] wheel1_speed;
    logic       wheel1_reverse;
    logic [7:0] wheel2_speed;
    logic       wheel2_reverse;
    logic [1:0] move_status;
    logic [1:0] wall_mode;
    logic       wall_update_open;
  } out_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
  } mac_ctrl_t;

  typedef struct packed {
    logic [7:0] speed;
    logic       reverse;
  } wheel_t;

  // Divide by 256 with truncation toward zero
  function automatic logic signed [CORR_W-1:0] scale_q88(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] biased;
    begin
      biased = v[ACC_W-1] ? (v + ACC_W'(255)) : v;
      scale_q88 = biased[ACC_W-1:8];
    end
  endfunction

  // Clamp to +-255 and split into magnitude and reverse bit
  function automatic wheel_t drive_wheel(input logic signed [CORR_W-1:0] v);
    logic signed [CORR_W-1:0] neg;
    wheel_t w;
    begin
      neg = -v;
      if (v > CORR_W'(255)) begin
        w.speed = 8'd255;
        w.reverse = 1'b0;
      end else if (v < -CORR_W'(255)) begin
        w.speed = 8'd255;
        w.reverse = 1'b1;
      end else if (v[CORR_W-1]) begin
        w.speed = neg[7:0];
        w.reverse = 1'b1;
      end else begin
        w.speed = v[7:0];
        w.reverse = 1'b0;
      end
      drive_wheel = w;
    end
  endfunction

endpackage

[rtl/wfpd_mac.sv]
// Shared signed multiply-accumulate unit: registered product, then accumulate.
`timescale 1ns / 1ps

module wfpd_mac (
  input  logic                                clk,
  input  wfpd_pkg::mac_ctrl_t                 ctrl,
  input  logic [15:0]                         gain,
  input  logic signed [wfpd_pkg::OPND_W-1:0]  operand,
  output logic signed [wfpd_pkg::ACC_W-1:0]   acc
);

  logic signed [wfpd_pkg::ACC_W-1:0] prod;
  logic signed [16:0]                gain_s;

  // Gains are unsigned Q8.8, widened with a zero sign bit
  assign gain_s = $signed({1'b0, gain});

  // Product register
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= gain_s * operand;
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (ctrl.acc_clr) begin
      acc <= '0;
    end else if (ctrl.acc_add) begin
      acc <= acc + prod;
    end
  end

endmodule

[rtl/wall_following_pd_drive.sv]
// Top level of the wall-following PD drive: sequencer, move state and output register.
//
// Usage: a begin beat (func = 0) on the input channel clears the move state
// and gives no result. Each tick beat (func = 1) carries both encoder counts
// and four IR readings and gives exactly one result beat on the output channel.
// Configuration registers are to be written through cfg_we / cfg_index / cfg_data
// only while the block is idle (the block itself does not enforce this); a write
// takes effect at the next clock edge. A tick runs through one shared
// multiply-accumulate unit: wall PD (two products, only when a side wall is
// seen) then encoder PD (two products), one product per cycle; a stopped move
// uses none. The sequencer steps through check, wall P, wall D, wall sum,
// error, drive P, drive D, drive sum, divide, finish and output; with no wall
// it skips the wall states, and a stopped move goes from check to output.
// in_ready rises together with out_valid, and a begin beat leaves it high.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver still stalls when the following result is ready,
// the sequencer holds that result until the register frees.
// Reset (rst, synchronous) restores register defaults, clears the move
// state and drops out_valid.
`timescale 1ns / 1ps

module wall_following_pd_drive (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wfpd_pkg::in_t       in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wfpd_pkg::out_t      out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_W_P   = 4'd2;
  localparam logic [3:0] S_W_D   = 4'd3;
  localparam logic [3:0] S_W_SUM = 4'd4;
  localparam logic [3:0] S_ERR   = 4'd5;
  localparam logic [3:0] S_D_P   = 4'd6;
  localparam logic [3:0] S_D_D   = 4'd7;
  localparam logic [3:0] S_D_SUM = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;

  // Configuration registers
  logic [11:0] left_wall_level;
  logic [11:0] right_wall_level;
  logic [11:0] front_stop_level;
  logic [7:0]  base_speed;
  logic [15:0] travel_target;
  logic [31:0] encoder_gains;
  logic [31:0] both_wall_gains;
  logic [31:0] side_wall_gains;

  // Move state
  logic signed [24:0] drive_prev_error;
  logic signed [13:0] wall_prev_error;
  logic [1:0]         move_finished;
  logic               updates_closed;

  // Working registers
  wfpd_pkg::in_t                        item;
  logic [1:0]                           mode;
  logic signed [13:0]                   wall_err;
  logic signed [25:0]                   delta;
  logic signed [24:0]                   drive_err;
  logic signed [wfpd_pkg::CORR_W-1:0]   corr;
  wfpd_pkg::out_t                       res;

  // MAC interface
  wfpd_pkg::mac_ctrl_t                  mac_ctrl;
  logic [15:0]                          mac_gain;
  logic signed [wfpd_pkg::OPND_W-1:0]   mac_opnd;
  logic signed [wfpd_pkg::ACC_W-1:0]    acc;

  // Combinational helpers
  logic               in_fire;
  logic signed [16:0] edge_sum;
  logic signed [16:0] edge_diff;
  logic [12:0]        front_sum;
  logic               hit_target;
  logic               hit_front;
  logic               left_wall;
  logic               right_wall;
  logic signed [12:0] err_left;
  logic signed [12:0] err_right;
  logic [1:0]         mode_c;
  logic signed [13:0] wall_err_c;
  logic signed [14:0] wall_delta;
  logic signed [25:0] drive_delta;
  logic signed [wfpd_pkg::CORR_W-1:0] steer;
  logic signed [wfpd_pkg::CORR_W-1:0] base_s;
  wfpd_pkg::wheel_t   wheel1;
  wfpd_pkg::wheel_t   wheel2;
  logic [31:0]        wall_gains;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      left_wall_level  <= wfpd_pkg::LEFT_WALL_LEVEL_RST;
      right_wall_level <= wfpd_pkg::RIGHT_WALL_LEVEL_RST;
      front_stop_level <= wfpd_pkg::FRONT_STOP_LEVEL_RST;
      base_speed       <= wfpd_pkg::BASE_SPEED_RST;
      travel_target    <= wfpd_pkg::TRAVEL_TARGET_RST;
      encoder_gains    <= wfpd_pkg::ENCODER_GAINS_RST;
      both_wall_gains  <= wfpd_pkg::BOTH_WALL_GAINS_RST;
      side_wall_gains  <= wfpd_pkg::SIDE_WALL_GAINS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wfpd_pkg::REG_LEFT_WALL_LEVEL:  left_wall_level  <= cfg_data[11:0];
        wfpd_pkg::REG_RIGHT_WALL_LEVEL: right_wall_level <= cfg_data[11:0];
        wfpd_pkg::REG_FRONT_STOP_LEVEL: front_stop_level <= cfg_data[11:0];
        wfpd_pkg::REG_BASE_SPEED:       base_speed       <= cfg_data[7:0];
        wfpd_pkg::REG_TRAVEL_TARGET:    travel_target    <= cfg_data[15:0];
        wfpd_pkg::REG_ENCODER_GAINS:    encoder_gains    <= cfg_data;
        wfpd_pkg::REG_BOTH_WALL_GAINS:  both_wall_gains  <= cfg_data;
        wfpd_pkg::REG_SIDE_WALL_GAINS:  side_wall_gains  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stop checks on the latched tick
  assign edge_sum   = $signed({item.wheel1_edges[15], item.wheel1_edges})
                    + $signed({item.wheel2_edges[15], item.wheel2_edges});
  assign edge_diff  = $signed({item.wheel2_edges[15], item.wheel2_edges})
                    - $signed({item.wheel1_edges[15], item.wheel1_edges});
  assign front_sum  = {1'b0, item.ir_front_a} + {1'b0, item.ir_front_b};
  assign hit_target = $signed({edge_sum[16], edge_sum}) >= $signed({2'b00, travel_target});
  assign hit_front  = front_sum[12:1] >= front_stop_level;

  // Side wall classification and wall error
  assign left_wall  = item.ir_side_left >= left_wall_level;
  assign right_wall = item.ir_side_right >= right_wall_level;
  assign err_left   = $signed({1'b0, left_wall_level}) - $signed({1'b0, item.ir_side_left});
  assign err_right  = $signed({1'b0, right_wall_level}) - $signed({1'b0, item.ir_side_right});

  always_comb begin
    if (left_wall && right_wall) begin
      mode_c     = wfpd_pkg::MODE_BOTH;
      wall_err_c = $signed({err_right[12], err_right}) - $signed({err_left[12], err_left});
    end else if (left_wall) begin
      mode_c     = wfpd_pkg::MODE_LEFT;
      wall_err_c = -$signed({err_left[12], err_left});
    end else if (right_wall) begin
      mode_c     = wfpd_pkg::MODE_RIGHT;
      wall_err_c = $signed({err_right[12], err_right});
    end else begin
      mode_c     = wfpd_pkg::MODE_NONE;
      wall_err_c = '0;
    end
  end

  // Differences for the D terms
  assign wall_delta  = $signed({wall_err[13], wall_err})
                     - $signed({wall_prev_error[13], wall_prev_error});
  assign drive_delta = $signed({drive_err[24], drive_err})
                     - $signed({drive_prev_error[24], drive_prev_error});

  // Steering term and final wheel drive
  assign steer  = (mode == wfpd_pkg::MODE_NONE) ? '0 : wfpd_pkg::scale_q88(acc);
  assign base_s = $signed({{(wfpd_pkg::CORR_W-8){1'b0}}, base_speed});
  assign wheel1 = wfpd_pkg::drive_wheel(base_s + corr);
  assign wheel2 = wfpd_pkg::drive_wheel(base_s - corr);

  // MAC operand selection
  assign wall_gains = (mode == wfpd_pkg::MODE_BOTH) ? both_wall_gains : side_wall_gains;

  always_comb begin
    mac_ctrl = '0;
    mac_gain = '0;
    mac_opnd = '0;
    unique case (state) inside
      S_W_P: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
        mac_gain = wall_gains[15:0];
        mac_opnd = {{(wfpd_pkg::OPND_W-14){wall_err[13]}}, wall_err};
      end
      S_W_D: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = 1'b1;
        mac_gain = wall_gains[31:16];
        mac_opnd = {{(wfpd_pkg::OPND_W-26){delta[25]}}, delta};
      end
      S_D_P: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_clr = 1'b1;
        mac_gain = encoder_gains[15:0];
        mac_opnd = {{(wfpd_pkg::OPND_W-25){drive_err[24]}}, drive_err};
      end
      S_D_D: begin
        mac_ctrl.mul_en  = 1'b1;
        mac_ctrl.acc_add = 1'b1;
        mac_gain = encoder_gains[31:16];
        mac_opnd = {{(wfpd_pkg::OPND_W-26){delta[25]}}, delta};
      end
      S_W_SUM, S_D_SUM: begin
        mac_ctrl.acc_add = 1'b1;
      end
      default: ;
    endcase
  end

  wfpd_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .gain    (mac_gain),
    .operand (mac_opnd),
    .acc     (acc)
  );

  // Sequencer and move state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      drive_prev_error <= '0;
      wall_prev_error  <= '0;
      move_finished    <= wfpd_pkg::STATUS_DRIVING;
      updates_closed   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.func == wfpd_pkg::FUNC_BEGIN) begin
              drive_prev_error <= '0;
              wall_prev_error  <= '0;
              move_finished    <= wfpd_pkg::STATUS_DRIVING;
              updates_closed   <= 1'b0;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (move_finished != wfpd_pkg::STATUS_DRIVING) begin
            state <= S_OUT;
          end else if (hit_target) begin
            move_finished <= wfpd_pkg::STATUS_TARGET;
            state <= S_OUT;
          end else if (hit_front) begin
            move_finished <= wfpd_pkg::STATUS_FRONT;
            state <= S_OUT;
          end else begin
            if ($signed({edge_sum[16], edge_sum}) > $signed({3'b000, travel_target[15:1]})) begin
              updates_closed <= 1'b1;
            end
            if (mode_c == wfpd_pkg::MODE_NONE) begin
              wall_prev_error <= '0;
              state <= S_ERR;
            end else begin
              state <= S_W_P;
            end
          end
        end
        S_W_P: begin
          wall_prev_error <= wall_err;
          state <= S_W_D;
        end
        S_W_D:   state <= S_W_SUM;
        S_W_SUM: state <= S_ERR;
        S_ERR:   state <= S_D_P;
        S_D_P: begin
          drive_prev_error <= drive_err;
          state <= S_D_D;
        end
        S_D_D:   state <= S_D_SUM;
        S_D_SUM: state <= S_DIV;
        S_DIV:   state <= S_FIN;
        S_FIN:   state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
    unique case (state)
      S_CHECK: begin
        mode     <= mode_c;
        wall_err <= wall_err_c;
        // Stopped result, used when the sequencer goes straight to output
        res.wheel1_speed     <= '0;
        res.wheel1_reverse   <= 1'b0;
        res.wheel2_speed     <= '0;
        res.wheel2_reverse   <= 1'b0;
        res.wall_mode        <= wfpd_pkg::MODE_NONE;
        res.wall_update_open <= !updates_closed;
        if (move_finished != wfpd_pkg::STATUS_DRIVING) begin
          res.move_status <= move_finished;
        end else if (hit_target) begin
          res.move_status <= wfpd_pkg::STATUS_TARGET;
        end else begin
          res.move_status <= wfpd_pkg::STATUS_FRONT;
        end
      end
      S_W_P: delta <= {{11{wall_delta[14]}}, wall_delta};
      S_ERR: drive_err <= $signed({{8{edge_diff[16]}}, edge_diff}) + steer[24:0];
      S_D_P: delta <= drive_delta;
      S_DIV: corr <= wfpd_pkg::scale_q88(acc);
      S_FIN: begin
        res.wheel1_speed     <= wheel1.speed;
        res.wheel1_reverse   <= wheel1.reverse;
        res.wheel2_speed     <= wheel2.speed;
        res.wheel2_reverse   <= wheel2.reverse;
        res.move_status      <= wfpd_pkg::STATUS_DRIVING;
        res.wall_mode        <= mode;
        res.wall_update_open <= !updates_closed;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

endmodule

[rtl/wfpd_checker.sv]
// Port-level checks of the wall-following PD drive, bound to the top level.
`timescale 1ns / 1ps

module wfpd_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input wfpd_pkg::in_t   in_data,
  input logic            out_valid,
  input logic            out_ready,
  input wfpd_pkg::out_t  out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // A tick beat keeps the sequencer busy for at least the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.func == wfpd_pkg::FUNC_TICK) |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // A stopped result drives nothing and reports no wall mode
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.move_status != wfpd_pkg::STATUS_DRIVING) |->
      (out_data.wheel1_speed == 8'd0) && (out_data.wheel2_speed == 8'd0) &&
      !out_data.wheel1_reverse && !out_data.wheel2_reverse &&
      (out_data.wall_mode == wfpd_pkg::MODE_NONE))
    else $error("stopped result carries drive");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.move_status == wfpd_pkg::STATUS_DRIVING) ||
                  (out_data.move_status == wfpd_pkg::STATUS_TARGET) ||
                  (out_data.move_status == wfpd_pkg::STATUS_FRONT))
    else $error("undefined move status");

  // Zero magnitude is never reported as reverse
  a_zero_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_data.wheel1_speed == 8'd0 && out_data.wheel1_reverse) ||
                  (out_data.wheel2_speed == 8'd0 && out_data.wheel2_reverse)) |-> 1'b0)
    else $error("reverse flagged with zero speed");

endmodule

bind wall_following_pd_drive wfpd_checker u_wfpd_checker (.*);
